// File: src/bptc_pkg.sv
// ============================================================================
// bptc_pkg
// Shared types and constants of the barometric pressure/temperature
// first-order compensation core.
// ============================================================================
`default_nettype none

package bptc_pkg;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 23;
    localparam int IDX_W   = 3;

    // internal datapath widths
    localparam int DT_W    = RAW_W + 1;
    localparam int CALS_W  = CAL_W + 1;
    localparam int PROD_W  = DT_W + CAL_W;
    localparam int OFF_W   = 35;
    localparam int SENS_W  = 34;
    localparam int PSD_W   = RAW_W + SENS_W;
    localparam int PSH_W   = 37;
    localparam int DIFF_W  = 38;

    // shift amounts of the first-order formulas
    localparam int REF_SHIFT  = 8;
    localparam int TEMP_SHIFT = 23;
    localparam int OFF_SCALE  = 16;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SCALE = 15;
    localparam int SENS_SHIFT = 8;
    localparam int PSD_SHIFT  = 21;
    localparam int PRES_SHIFT = 15;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    typedef enum logic [IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } cfg_idx_t;

endpackage

`default_nettype wire

// File: src/bptc_sample_if.sv
// ============================================================================
// bptc_sample_if
// Input channel: one raw pressure and one raw temperature conversion.
// ============================================================================
`default_nettype none

interface bptc_sample_if;
    logic                           valid;
    logic                           ready;
    logic [bptc_pkg::RAW_W-1:0]     raw_pressure;
    logic [bptc_pkg::RAW_W-1:0]     raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

`default_nettype wire

// File: src/bptc_result_if.sv
// ============================================================================
// bptc_result_if
// Output channel: compensated temperature and pressure.
// ============================================================================
`default_nettype none

interface bptc_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bptc_pkg::TEMP_W-1:0]     temperature_centideg;
    logic signed [bptc_pkg::PRES_W-1:0]     pressure_centimbar;

    modport source (output valid, output temperature_centideg, output pressure_centimbar,
                    input ready);
    modport sink   (input valid, input temperature_centideg, input pressure_centimbar,
                    output ready);
endinterface

`default_nettype wire

// File: src/baro_pressure_temp_compensation_core.sv
// ============================================================================
// baro_pressure_temp_compensation_core
// First-order compensation of raw barometric sensor conversions.
//
// The sample channel takes one word per cycle while sample.ready is high,
// holding raw pressure D1 and raw temperature D2. The result channel
// returns one word per sample with temperature in 0.01 degC and pressure
// in 0.01 mbar, in order. The six calibration words are written over
// wr_en/wr_index/wr_data; indexes past the last word are ignored. The
// user must write them only while the core is idle; the core itself does
// not enforce this. From sample to result a word passes five register
// stages: reference subtract, three temperature products, TEMP/offset/
// sensitivity sums, the D1 x SENS product and the final subtract/shift.
// Reset clears all stage valid bits and the calibration words to zero.
// When the receiver stalls, each stage holds only if the one after it is
// full, so empty stages keep filling; sample.ready drops once all five
// stages hold words.
// ============================================================================
`default_nettype none

module baro_pressure_temp_compensation_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [bptc_pkg::IDX_W-1:0]     wr_index,
    input  wire logic [bptc_pkg::CAL_W-1:0]     wr_data,
    bptc_sample_if.sink                         sample,
    bptc_result_if.source                       result
);

    localparam int NSTG = 5;

    // calibration words
    logic [bptc_pkg::CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (wr_en)
        begin
            case (bptc_pkg::cfg_idx_t'(wr_index))
                bptc_pkg::REG_C1: c1_reg <= wr_data;
                bptc_pkg::REG_C2: c2_reg <= wr_data;
                bptc_pkg::REG_C3: c3_reg <= wr_data;
                bptc_pkg::REG_C4: c4_reg <= wr_data;
                bptc_pkg::REG_C5: c5_reg <= wr_data;
                bptc_pkg::REG_C6: c6_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // stage valid bits and advance chain
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !v_reg[NSTG-1] || result.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign sample.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= sample.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: dT = D2 - C5 * 2^8
    logic signed [bptc_pkg::DT_W-1:0]   dt_reg, dt_next;
    logic [bptc_pkg::RAW_W-1:0]         d1_s1_reg;

    assign dt_next = $signed({1'b0, sample.raw_temperature})
                   - $signed({1'b0, c5_reg, {bptc_pkg::REF_SHIFT{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dt_reg    <= dt_next;
            d1_s1_reg <= sample.raw_pressure;
        end
    end

    // stage 2: temperature products
    logic signed [bptc_pkg::PROD_W:0]   mt, mo, ms;
    logic signed [bptc_pkg::PROD_W-1:0] pt_reg, po_reg, ps_reg;
    logic [bptc_pkg::RAW_W-1:0]         d1_s2_reg;

    assign mt = dt_reg * $signed({1'b0, c6_reg});
    assign mo = dt_reg * $signed({1'b0, c4_reg});
    assign ms = dt_reg * $signed({1'b0, c3_reg});

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pt_reg    <= mt[bptc_pkg::PROD_W-1:0];
            po_reg    <= mo[bptc_pkg::PROD_W-1:0];
            ps_reg    <= ms[bptc_pkg::PROD_W-1:0];
            d1_s2_reg <= d1_s1_reg;
        end
    end

    // stage 3: TEMP, OFF and SENS
    logic signed [bptc_pkg::PROD_W-1:0] t_sh, o_sh, s_sh;
    logic signed [bptc_pkg::TEMP_W-1:0] temp_s3_reg, temp_s3_next;
    logic signed [bptc_pkg::OFF_W-1:0]  off_s3_reg, off_s3_next;
    logic signed [bptc_pkg::SENS_W-1:0] sens_reg, sens_next;
    logic [bptc_pkg::RAW_W-1:0]         d1_s3_reg;

    assign t_sh = pt_reg >>> bptc_pkg::TEMP_SHIFT;
    assign o_sh = po_reg >>> bptc_pkg::OFF_SHIFT;
    assign s_sh = ps_reg >>> bptc_pkg::SENS_SHIFT;

    assign temp_s3_next = $signed(t_sh[bptc_pkg::TEMP_W-1:0]) + bptc_pkg::TEMP_BASE;
    assign off_s3_next  = $signed({3'b000, c2_reg, {bptc_pkg::OFF_SCALE{1'b0}}})
                        + $signed(o_sh[bptc_pkg::OFF_W-1:0]);
    assign sens_next    = $signed({3'b000, c1_reg, {bptc_pkg::SENS_SCALE{1'b0}}})
                        + $signed(s_sh[bptc_pkg::SENS_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            temp_s3_reg <= temp_s3_next;
            off_s3_reg  <= off_s3_next;
            sens_reg    <= sens_next;
            d1_s3_reg   <= d1_s2_reg;
        end
    end

    // stage 4: D1 * SENS
    logic signed [bptc_pkg::PSD_W:0]    mp;
    logic signed [bptc_pkg::PSD_W-1:0]  psd_reg;
    logic signed [bptc_pkg::TEMP_W-1:0] temp_s4_reg;
    logic signed [bptc_pkg::OFF_W-1:0]  off_s4_reg;

    assign mp = $signed({1'b0, d1_s3_reg}) * sens_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            psd_reg     <= mp[bptc_pkg::PSD_W-1:0];
            temp_s4_reg <= temp_s3_reg;
            off_s4_reg  <= off_s3_reg;
        end
    end

    // stage 5: P = ((D1 * SENS) >> 21 - OFF) >> 15
    logic signed [bptc_pkg::PSD_W-1:0]  q_sh;
    logic signed [bptc_pkg::DIFF_W-1:0] diff, p_sh;
    logic signed [bptc_pkg::TEMP_W-1:0] temp_out_reg;
    logic signed [bptc_pkg::PRES_W-1:0] pres_out_reg;

    assign q_sh = psd_reg >>> bptc_pkg::PSD_SHIFT;
    assign diff = $signed({q_sh[bptc_pkg::PSH_W-1], q_sh[bptc_pkg::PSH_W-1:0]})
                - $signed({{(bptc_pkg::DIFF_W - bptc_pkg::OFF_W){off_s4_reg[bptc_pkg::OFF_W-1]}},
                           off_s4_reg});
    assign p_sh = diff >>> bptc_pkg::PRES_SHIFT;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            temp_out_reg <= temp_s4_reg;
            pres_out_reg <= p_sh[bptc_pkg::PRES_W-1:0];
        end
    end

    assign result.valid                = v_reg[NSTG-1];
    assign result.temperature_centideg = temp_out_reg;
    assign result.pressure_centimbar   = pres_out_reg;

    // checks
    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> v_reg[0])
        else $error("accepted word not captured in first stage");

    a_empty_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg == '0 |-> sample.ready)
        else $error("empty pipeline refuses input");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !adv[1] |=> v_reg[0] && $stable(dt_reg))
        else $error("stalled first stage lost or changed its word");

endmodule

`default_nettype wire
